### design/mtdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtdg_pkg
// Constants, sequencer states and the tempering function of the MT19937
// fraction generator.
// ----------------------------------------------------------------------------
package mtdg_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned PAIR_COUNT    = STATE_WORDS / 2;
  localparam int unsigned IDX_W         = $clog2(STATE_WORDS);
  localparam int unsigned PAIR_W        = $clog2(PAIR_COUNT + 1);
  localparam int unsigned FRAC_W        = 53;
  localparam int unsigned MANT_W        = 52;

  localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] TOP_BIT      = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [FRAC_W-1:0] ONE_FIXED = 53'h10_0000_0000_0000;

  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0]  MID_WRAP    = IDX_W'(STATE_WORDS - MIDDLE_OFFSET);
  localparam logic [IDX_W-1:0]  MID_OFS     = IDX_W'(MIDDLE_OFFSET);
  localparam logic [PAIR_W-1:0] PAIR_ALL    = PAIR_W'(PAIR_COUNT);

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef enum logic [1:0] {
    MODE_ONE_TWO    = 2'd0,
    MODE_CLOSE_OPEN = 2'd1,
    MODE_OPEN_CLOSE = 2'd2,
    MODE_OPEN_OPEN  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_REGEN_CUR,
    ST_REGEN_NXT,
    ST_REGEN_MID,
    ST_REGEN_WR,
    ST_DRAW_LO,
    ST_DRAW_HI,
    ST_DRAW_FIN,
    ST_UNSEEDED
  } state_e;

  function automatic logic [31:0] temper_word(input logic [31:0] v);
    logic [31:0] a, b, c;
    a = v ^ (v >> 11);
    b = a ^ ((a << 7) & TEMPER_B);
    c = b ^ ((b << 15) & TEMPER_C);
    return c ^ (c >> 18);
  endfunction

endpackage

### design/mt19937_double_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_double_generator
// MT19937 generator giving 52-bit uniform fractions in one of four intervals.
// ----------------------------------------------------------------------------
// Seed word: word 0 on accept, then one multiply and one add per later word.
// Draw word: accept, two reads of the single RAM read port, result on a free slot.
// Every 312th draw first regenerates the state: three reads and one write per
// word through the single RAM port pair. Unseeded draw: accept, flagged result.
// Reset clears control state and the mode register; the state RAM is
// undefined until the first seed word.
module mt19937_double_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,     // interval_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,    // [31:0] seed_value
  input  logic [0:0]  s_axis_tuser,    // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,    // [52:0] fraction, zero fill above
  output logic [0:0]  m_axis_tuser     // [0] unseeded
);
  import mtdg_pkg::*;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [PAIR_W-1:0] pair_q, pair_d;
  logic              seeded_q, seeded_d;
  mode_e             mode_q;
  logic [31:0]       prev_q, prev_d;
  logic [31:0]       mul_q, mul_d;
  logic [31:0]       cur_q, cur_d;
  logic [31:0]       nxt_q, nxt_d;
  logic [31:0]       lo_q, lo_d;
  logic              out_valid_q, out_valid_d;
  logic [FRAC_W-1:0] out_frac_q, out_frac_d;
  logic              out_unseeded_q, out_unseeded_d;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;

  logic              in_fire, slot_free;
  logic [IDX_W-1:0]  nxt_idx, mid_idx;
  logic [31:0]       seed_word, twist_y, twist_word, hi_t;
  logic [MANT_W-1:0] mant;
  logic [FRAC_W-1:0] frac;

  mtdg_ram #(
    .WIDTH(32),
    .DEPTH(STATE_WORDS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign slot_free     = ~out_valid_q | m_axis_tready;

  assign nxt_idx    = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
  assign mid_idx    = (idx_q < MID_WRAP) ? idx_q + MID_OFS : idx_q - MID_WRAP;
  assign seed_word  = mul_q + 32'(idx_q);
  assign twist_y    = (cur_q & TOP_BIT) | (nxt_q & LOW_BITS);
  assign twist_word = ram_rdata ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'h0);
  assign hi_t       = temper_word(ram_rdata);
  assign mant       = {hi_t[MANT_W-33:0], lo_q};

  always_comb begin
    unique case (mode_q)
      MODE_OPEN_CLOSE: frac = ONE_FIXED - {1'b0, mant};
      MODE_OPEN_OPEN:  frac = {1'b0, mant[MANT_W-1:1], 1'b1};
      default:         frac = {1'b0, mant};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser[0] == OP_SEED) begin
            state_d = ST_SEED_MUL;
          end else if (!seeded_q) begin
            state_d = ST_UNSEEDED;
          end else if (pair_q >= PAIR_ALL) begin
            state_d = ST_REGEN_CUR;
          end else begin
            state_d = ST_DRAW_LO;
          end
        end
      end
      ST_SEED_MUL:  state_d = ST_SEED_ADD;
      ST_SEED_ADD:  state_d = (idx_q == LAST_IDX) ? ST_IDLE : ST_SEED_MUL;
      ST_REGEN_CUR: state_d = ST_REGEN_NXT;
      ST_REGEN_NXT: state_d = ST_REGEN_MID;
      ST_REGEN_MID: state_d = ST_REGEN_WR;
      ST_REGEN_WR:  state_d = (idx_q == LAST_IDX) ? ST_DRAW_LO : ST_REGEN_CUR;
      ST_DRAW_LO:   state_d = ST_DRAW_HI;
      ST_DRAW_HI:   state_d = ST_DRAW_FIN;
      ST_DRAW_FIN: begin
        if (slot_free) state_d = ST_IDLE;
      end
      ST_UNSEEDED: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d          = idx_q;
    pair_d         = pair_q;
    seeded_d       = seeded_q;
    prev_d         = prev_q;
    mul_d          = mul_q;
    cur_d          = cur_q;
    nxt_d          = nxt_q;
    lo_d           = lo_q;
    out_valid_d    = out_valid_q & ~m_axis_tready;
    out_frac_d     = out_frac_q;
    out_unseeded_d = out_unseeded_q;
    ram_we         = 1'b0;
    ram_waddr      = idx_q;
    ram_wdata      = twist_word;
    ram_re         = 1'b0;
    ram_raddr      = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_fire && s_axis_tuser[0] == OP_SEED) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = s_axis_tdata;
          prev_d    = s_axis_tdata;
          idx_d     = IDX_W'(1);
          seeded_d  = 1'b1;
          pair_d    = PAIR_ALL;
        end
      end
      ST_SEED_MUL: begin
        mul_d = SEED_MULT * (prev_q ^ (prev_q >> 30));
      end
      ST_SEED_ADD: begin
        ram_we    = 1'b1;
        ram_wdata = seed_word;
        prev_d    = seed_word;
        idx_d     = nxt_idx;
      end
      ST_REGEN_CUR: begin
        ram_re = 1'b1;
      end
      ST_REGEN_NXT: begin
        ram_re    = 1'b1;
        ram_raddr = nxt_idx;
        cur_d     = ram_rdata;
      end
      ST_REGEN_MID: begin
        ram_re    = 1'b1;
        ram_raddr = mid_idx;
        nxt_d     = ram_rdata;
      end
      ST_REGEN_WR: begin
        ram_we = 1'b1;
        idx_d  = nxt_idx;
        if (idx_q == LAST_IDX) pair_d = '0;
      end
      ST_DRAW_LO: begin
        ram_re    = 1'b1;
        ram_raddr = {pair_q, 1'b0};
      end
      ST_DRAW_HI: begin
        ram_re    = 1'b1;
        ram_raddr = {pair_q, 1'b1};
        lo_d      = temper_word(ram_rdata);
      end
      ST_DRAW_FIN: begin
        if (slot_free) begin
          out_valid_d    = 1'b1;
          out_frac_d     = frac;
          out_unseeded_d = 1'b0;
          pair_d         = pair_q + PAIR_W'(1);
        end
      end
      ST_UNSEEDED: begin
        if (slot_free) begin
          out_valid_d    = 1'b1;
          out_frac_d     = '0;
          out_unseeded_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pair_q      <= PAIR_ALL;
      seeded_q    <= 1'b0;
      mode_q      <= MODE_ONE_TWO;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pair_q      <= pair_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q         <= prev_d;
    mul_q          <= mul_d;
    cur_q          <= cur_d;
    nxt_q          <= nxt_d;
    lo_q           <= lo_d;
    out_frac_q     <= out_frac_d;
    out_unseeded_q <= out_unseeded_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {3'b000, out_frac_q};
  assign m_axis_tuser[0] = out_unseeded_q;

endmodule

### design/mtdg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtdg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtdg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MT19937 fraction generator. Seed and draw words
// go in through the input stream with random gaps. A bit-exact model of the
// generator state predicts each result word. Results are checked in order on
// the output stream under random backpressure, with two long hold-offs. The
// interval mode is changed between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import mtdg_pkg::*;

  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] HI_BIT    = 32'h8000_0000;
  localparam logic [31:0] LO_MASK   = 32'h7fff_ffff;
  localparam logic [31:0] TEMP_B    = 32'h9d2c_5680;
  localparam logic [31:0] TEMP_C    = 32'hefc6_0000;
  localparam logic [31:0] INIT_MULT = 32'd1812433253;

  localparam int SEED_LATENCY   = 1400;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RAND_PHASE_LEN = 205;

  typedef struct packed {
    logic        op;
    logic [31:0] seed;
  } gen_req_t;

  typedef struct {
    logic [FRAC_W-1:0] fraction;
    logic              unseeded;
  } frac_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_wdata_i   = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = 32'd0;
  logic [0:0]  s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  gen_req_t   pending_reqs[$];
  frac_word_t expected_fracs[$];
  int         reqs_issued   = 0;
  int         reqs_taken    = 0;
  int         results_seen  = 0;
  int         mismatches    = 0;
  int         hold_left     = 0;
  int         quiet_cycles  = 0;

  logic [31:0] mt_state [STATE_WORDS];
  int unsigned pair_pos     = PAIR_COUNT;
  logic        seeded       = 1'b0;
  mode_e       interval_sel = MODE_ONE_TWO;

  mt19937_double_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- generator model ----

  function automatic logic [31:0] temper(logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMP_B);
    t = t ^ ((t << 15) & TEMP_C);
    return t ^ (t >> 18);
  endfunction

  function automatic void load_seed(logic [31:0] s);
    logic [31:0] p;
    mt_state[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      p = mt_state[i-1];
      mt_state[i] = INIT_MULT * (p ^ (p >> 30)) + 32'(i);
    end
    pair_pos = PAIR_COUNT;
    seeded = 1'b1;
  endfunction

  function automatic void twist_state();
    int unsigned nxt;
    int unsigned mid;
    logic [31:0] y;
    for (int i = 0; i < STATE_WORDS; i++) begin
      nxt = (i + 1) % STATE_WORDS;
      mid = (i + MIDDLE_OFFSET) % STATE_WORDS;
      y = (mt_state[i] & HI_BIT) | (mt_state[nxt] & LO_MASK);
      mt_state[i] = mt_state[mid] ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
    end
    pair_pos = 0;
  endfunction

  function automatic void predict_fraction(logic op, logic [31:0] s);
    frac_word_t  w;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [MANT_W-1:0] m;
    if (op == OP_SEED) begin
      load_seed(s);
      return;
    end
    w.unseeded = !seeded;
    w.fraction = '0;
    if (seeded) begin
      if (pair_pos >= PAIR_COUNT) twist_state();
      lo = temper(mt_state[2*pair_pos]);
      hi = temper(mt_state[2*pair_pos+1]);
      pair_pos++;
      m = {hi[19:0], lo};
      case (interval_sel)
        MODE_OPEN_CLOSE: w.fraction = (FRAC_W'(1) << MANT_W) - {1'b0, m};
        MODE_OPEN_OPEN:  w.fraction = {1'b0, m | MANT_W'(1)};
        default:         w.fraction = {1'b0, m};
      endcase
    end
    expected_fracs.push_back(w);
  endfunction

  // ---- input side ----

  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    gen_req_t req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 32'd0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_fraction(s_axis_tuser[0], s_axis_tdata);
        reqs_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() != 0 &&
            ((reqs_taken >= 400 && reqs_taken < 560) || $urandom_range(99) >= 33)) begin
          req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req.op;
          s_axis_tdata  <= req.seed;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- output side ----

  always @(posedge clk_i or negedge rst_ni) begin : mon_blk
    frac_word_t want;
    bit         mark;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else begin
      mark = 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        mark = (results_seen == 350 || results_seen == 700);
        if (expected_fracs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: fraction %h unseeded %b",
                     m_axis_tdata[FRAC_W-1:0], m_axis_tuser[0]);
        end else begin
          want = expected_fracs.pop_front();
          if (m_axis_tdata[FRAC_W-1:0] !== want.fraction ||
              m_axis_tuser[0] !== want.unseeded) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word %0d: fraction exp %h got %h, unseeded exp %b got %b",
                       results_seen, want.fraction, m_axis_tdata[FRAC_W-1:0],
                       want.unseeded, m_axis_tuser[0]);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (mark) begin
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (results_seen >= 400 && results_seen < 560) ||
                         $urandom_range(99) >= 33;
      end
    end
  end

  // ---- watchdog ----

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---- stimulus ----

  task automatic add_req(logic op, logic [31:0] s);
    pending_reqs.push_back('{op: op, seed: s});
    reqs_issued++;
  endtask

  task automatic add_draws(int n);
    repeat (n) add_req(OP_DRAW, $urandom());
  endtask

  task automatic drain();
    while (reqs_taken != reqs_issued || expected_fracs.size() != 0) @(posedge clk_i);
    repeat (SEED_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_mode(mode_e m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    interval_sel = m;
  endtask

  task automatic add_random(int n);
    repeat (n) begin
      if ($urandom_range(249) == 0)
        add_req(OP_SEED, $urandom());
      else
        add_draws(1);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // draws before any seed, then extreme seeds in the reset mode
    add_draws(2);
    add_req(OP_SEED, 32'hffff_ffff);
    add_draws(3);
    add_req(OP_SEED, 32'h0000_0000);
    add_draws(2);

    write_mode(MODE_OPEN_OPEN);
    add_draws(2);
    add_req(OP_SEED, 32'd5489);
    add_draws(2);

    write_mode(MODE_OPEN_CLOSE);
    add_draws(3);

    write_mode(MODE_CLOSE_OPEN);
    add_draws(2);
    add_req(OP_SEED, 32'h8000_0001);
    add_draws(2);

    write_mode(MODE_ONE_TWO);
    add_draws(2);

    write_mode(MODE_OPEN_OPEN);
    add_random(RAND_PHASE_LEN);
    write_mode(MODE_ONE_TWO);
    add_random(RAND_PHASE_LEN);
    write_mode(MODE_OPEN_CLOSE);
    add_random(RAND_PHASE_LEN);
    write_mode(MODE_CLOSE_OPEN);
    add_random(RAND_PHASE_LEN);
    write_mode(mode_e'($urandom_range(3)));
    add_random(RAND_PHASE_LEN);

    drain();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
